>>> hdl/qlrelu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized leaky ReLU package
// Widths, register indexes, reset values and pipeline beat types.
// ----------------------------------------------------------------------------
package qlrelu_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned DiffW    = 17;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned PosMultW = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IN_ZP     = 3'd0,
    REG_OUT_ZP    = 3'd1,
    REG_POS_MULT  = 3'd2,
    REG_POS_SHIFT = 3'd3,
    REG_NEG_MULT  = 3'd4,
    REG_NEG_SHIFT = 3'd5,
    REG_OUT_MIN   = 3'd6,
    REG_OUT_MAX   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0]  in_zero_point;
    logic signed [DataW-1:0]  out_zero_point;
    logic [PosMultW-1:0]      pos_multiplier;
    logic signed [ShiftW-1:0] pos_shift;
    logic signed [AccW-1:0]   neg_multiplier;
    logic signed [ShiftW-1:0] neg_shift;
    logic signed [DataW-1:0]  out_min;
    logic signed [DataW-1:0]  out_max;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    in_zero_point:  16'sd0,
    out_zero_point: 16'sd0,
    pos_multiplier: 31'h4000_0000,
    pos_shift:      6'sd1,
    neg_multiplier: 32'sd0,
    neg_shift:      6'sd0,
    out_min:        -16'sd128,
    out_max:        16'sd127
  };

  localparam logic signed [AccW-1:0] AccMax = 32'sh7FFF_FFFF;
  localparam logic signed [AccW-1:0] AccMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [AccW-1:0] pre;
    logic signed [AccW-1:0] mult;
    logic [ShiftW-1:0]      rshift;
    logic                   last;
  } pre_beat_t;

  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic                    ovf;
    logic [ShiftW-1:0]       rshift;
    logic                    last;
  } prod_beat_t;

  typedef struct packed {
    logic signed [AccW-1:0] high;
    logic [ShiftW-1:0]      rshift;
    logic                   last;
  } high_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } out_beat_t;

endpackage
`default_nettype wire

>>> hdl/qlrelu_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized leaky ReLU configuration registers
// Holds the zero points, scale factors and output range, written by index.
// ----------------------------------------------------------------------------
module qlrelu_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [qlrelu_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [qlrelu_pkg::CfgDataW-1:0]   cfg_data_i,
  output qlrelu_pkg::cfg_t                       cfg_o
);

  qlrelu_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (qlrelu_pkg::cfg_reg_e'(cfg_index_i))
        qlrelu_pkg::REG_IN_ZP:     cfg_d.in_zero_point  = cfg_data_i[qlrelu_pkg::DataW-1:0];
        qlrelu_pkg::REG_OUT_ZP:    cfg_d.out_zero_point = cfg_data_i[qlrelu_pkg::DataW-1:0];
        qlrelu_pkg::REG_POS_MULT:  cfg_d.pos_multiplier = cfg_data_i[qlrelu_pkg::PosMultW-1:0];
        qlrelu_pkg::REG_POS_SHIFT: cfg_d.pos_shift      = cfg_data_i[qlrelu_pkg::ShiftW-1:0];
        qlrelu_pkg::REG_NEG_MULT:  cfg_d.neg_multiplier = cfg_data_i[qlrelu_pkg::AccW-1:0];
        qlrelu_pkg::REG_NEG_SHIFT: cfg_d.neg_shift      = cfg_data_i[qlrelu_pkg::ShiftW-1:0];
        qlrelu_pkg::REG_OUT_MIN:   cfg_d.out_min        = cfg_data_i[qlrelu_pkg::DataW-1:0];
        qlrelu_pkg::REG_OUT_MAX:   cfg_d.out_max        = cfg_data_i[qlrelu_pkg::DataW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= qlrelu_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/qlrelu_pipe_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized leaky ReLU pipeline register
// One stage of beat storage with valid and stall; a bubble never blocks.
// ----------------------------------------------------------------------------
module qlrelu_pipe_reg #(
  parameter int unsigned Width = qlrelu_pkg::DataW
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             stall_i,
  output logic [Width-1:0]      data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  assign stall_o = valid_q & stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/qlrelu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized leaky ReLU datapath
// Four stages: pre-shift, multiply, rounding high half, rescale and clamp.
// ----------------------------------------------------------------------------
module qlrelu_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire qlrelu_pkg::cfg_t                  cfg_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [qlrelu_pkg::DataW-1:0] in_value_i,
  input  wire logic                              in_last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [qlrelu_pkg::DataW-1:0]    out_value_o,
  output logic                                   out_last_o
);

  localparam int unsigned WideW = qlrelu_pkg::DiffW + qlrelu_pkg::AccW - 1;
  localparam int unsigned NudgeW = qlrelu_pkg::ProdW + 1;
  localparam int unsigned RoundW = qlrelu_pkg::AccW + 1;
  localparam int unsigned SumW   = RoundW + 2;
  localparam logic signed [NudgeW-1:0] Nudge = NudgeW'(1) <<< (qlrelu_pkg::AccW - 2);

  qlrelu_pkg::pre_beat_t  pre_d, pre_q;
  qlrelu_pkg::prod_beat_t prod_d, prod_q;
  qlrelu_pkg::high_beat_t high_d, high_q;
  qlrelu_pkg::out_beat_t  res_d, res_q;

  logic pre_valid, prod_valid, high_valid;
  logic pre_stall, prod_stall, high_stall;

  logic signed [qlrelu_pkg::DiffW-1:0]  diff;
  logic                                 neg_side;
  logic signed [qlrelu_pkg::ShiftW-1:0] shift;
  logic [qlrelu_pkg::ShiftW-2:0]        lshift;
  logic signed [WideW-1:0]              wide;
  logic                                 fits;

  logic signed [NudgeW-1:0]             acc;

  logic signed [RoundW-1:0]             x_ext;
  logic signed [RoundW-1:0]             floor_val;
  logic [RoundW-1:0]                    mask;
  logic [RoundW-1:0]                    rem;
  logic [RoundW-1:0]                    thr;
  logic                                 round_up;
  logic signed [SumW-1:0]               sum;
  logic signed [SumW-1:0]               min_ext;
  logic signed [SumW-1:0]               max_ext;
  logic signed [SumW-1:0]               clamped;

  always_comb begin
    diff     = {in_value_i[qlrelu_pkg::DataW-1], in_value_i}
             - {cfg_i.in_zero_point[qlrelu_pkg::DataW-1], cfg_i.in_zero_point};
    neg_side = diff[qlrelu_pkg::DiffW-1];
    shift    = neg_side ? cfg_i.neg_shift : cfg_i.pos_shift;
    lshift   = (!shift[qlrelu_pkg::ShiftW-1] && (shift != '0))
             ? shift[qlrelu_pkg::ShiftW-2:0] : '0;
    wide     = $signed({{(WideW-qlrelu_pkg::DiffW){diff[qlrelu_pkg::DiffW-1]}}, diff}) <<< lshift;
    fits     = (&wide[WideW-1:qlrelu_pkg::AccW-1]) | ~(|wide[WideW-1:qlrelu_pkg::AccW-1]);

    pre_d.pre    = fits ? wide[qlrelu_pkg::AccW-1:0]
                 : (wide[WideW-1] ? qlrelu_pkg::AccMin : qlrelu_pkg::AccMax);
    pre_d.mult   = neg_side ? cfg_i.neg_multiplier : {1'b0, cfg_i.pos_multiplier};
    pre_d.rshift = shift[qlrelu_pkg::ShiftW-1] ? qlrelu_pkg::ShiftW'(-shift) : '0;
    pre_d.last   = in_last_i;
  end

  qlrelu_pipe_reg #(.Width($bits(qlrelu_pkg::pre_beat_t))) u_pre_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (pre_d),
    .valid_o (pre_valid),
    .stall_i (pre_stall),
    .data_o  (pre_q)
  );

  always_comb begin
    prod_d.prod   = $signed(pre_q.pre) * $signed(pre_q.mult);
    prod_d.ovf    = (pre_q.pre == qlrelu_pkg::AccMin) && (pre_q.mult == qlrelu_pkg::AccMin);
    prod_d.rshift = pre_q.rshift;
    prod_d.last   = pre_q.last;
  end

  qlrelu_pipe_reg #(.Width($bits(qlrelu_pkg::prod_beat_t))) u_prod_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_valid),
    .stall_o (pre_stall),
    .data_i  (prod_d),
    .valid_o (prod_valid),
    .stall_i (prod_stall),
    .data_o  (prod_q)
  );

  // Adding half an LSB and taking the floor matches the truncating divide
  // with a sign-dependent nudge for both signs of the product.
  always_comb begin
    acc           = $signed({prod_q.prod[qlrelu_pkg::ProdW-1], prod_q.prod}) + Nudge;
    high_d.high   = prod_q.ovf ? qlrelu_pkg::AccMax
                  : acc[qlrelu_pkg::AccW+qlrelu_pkg::AccW-2:qlrelu_pkg::AccW-1];
    high_d.rshift = prod_q.rshift;
    high_d.last   = prod_q.last;
  end

  qlrelu_pipe_reg #(.Width($bits(qlrelu_pkg::high_beat_t))) u_high_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .stall_o (prod_stall),
    .data_i  (high_d),
    .valid_o (high_valid),
    .stall_i (high_stall),
    .data_o  (high_q)
  );

  always_comb begin
    x_ext     = {high_q.high[qlrelu_pkg::AccW-1], high_q.high};
    floor_val = x_ext >>> high_q.rshift;
    mask      = (RoundW'(1) << high_q.rshift) - RoundW'(1);
    rem       = x_ext & mask;
    thr       = (mask >> 1) + RoundW'(high_q.high[qlrelu_pkg::AccW-1]);
    round_up  = rem > thr;
    min_ext   = SumW'(cfg_i.out_min);
    max_ext   = SumW'(cfg_i.out_max);
    sum       = SumW'(floor_val) + SumW'(round_up) + SumW'(cfg_i.out_zero_point);
    clamped   = sum;
    if (clamped < min_ext) begin
      clamped = min_ext;
    end
    if (clamped > max_ext) begin
      clamped = max_ext;
    end
    res_d.value = clamped[qlrelu_pkg::DataW-1:0];
    res_d.last  = high_q.last;
  end

  qlrelu_pipe_reg #(.Width($bits(qlrelu_pkg::out_beat_t))) u_res_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (high_valid),
    .stall_o (high_stall),
    .data_i  (res_d),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_q)
  );

  assign out_value_o = res_q.value;
  assign out_last_o  = res_q.last;

  // Back-pressure reaches the input only when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pre_valid && prod_valid && high_valid && out_valid_o))
    else $error("input stalled while the pipeline has a bubble");

  // A non-negative pre-shifted value only comes from the positive side.
  a_pos_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pre_valid && !pre_q.pre[qlrelu_pkg::AccW-1]) |-> !pre_q.mult[qlrelu_pkg::AccW-1])
    else $error("negative multiplier paired with a non-negative operand");

  // The overflow flag marks exactly the product of two most-negative operands.
  a_ovf_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid && prod_q.ovf) |->
      (prod_q.prod == (qlrelu_pkg::ProdW'(1) << (qlrelu_pkg::ProdW - 2))))
    else $error("overflow flag without the overflowing product");

endmodule
`default_nettype wire

>>> hdl/quantized_leaky_relu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quantized leaky ReLU
// Requantizes each sample with a sign-selected scale, adds the output zero
// point and clamps to the configured range.
//
//   Channel  Handshake               Beat contents
//   in       in_valid_i/in_stall_o   in_value_i, in_last_i
//   out      out_valid_o/out_stall_i out_value_o, out_last_o
//   cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample per cycle while the output does not stall; each sample passes
// through the four pipeline registers: pre-shift, multiply, rounding high
// half, and the output register.
// Reset empties the pipeline and loads the register defaults.
// An output stall holds the full stages from the output back to the first
// bubble and reaches in_stall_o only when all four stages are occupied.
// ----------------------------------------------------------------------------
module quantized_leaky_relu (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [qlrelu_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [qlrelu_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [qlrelu_pkg::DataW-1:0] in_value_i,
  input  wire logic                                in_last_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [qlrelu_pkg::DataW-1:0]      out_value_o,
  output logic                                     out_last_o
);

  qlrelu_pkg::cfg_t cfg;

  qlrelu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  qlrelu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_value_i  (in_value_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o)
  );

endmodule
`default_nettype wire
